@@ design/bdhc_pkg.sv @@
// package for the button debounce and hold classifier
// holds widths, reset values, register indexes and shared structs
// no dependencies
package bdhc_pkg;

  localparam int CNT_W      = 4;
  localparam int HOLD_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CNT_W-1:0]  RST_WINDOW_LENGTH = CNT_W'(10);
  localparam logic [CNT_W-1:0]  RST_MAJORITY      = CNT_W'(5);
  localparam logic [HOLD_W-1:0] RST_GREEN_START   = HOLD_W'(200);
  localparam logic [HOLD_W-1:0] RST_GREEN_END     = HOLD_W'(500);
  localparam logic [HOLD_W-1:0] RST_RED_START     = HOLD_W'(600);
  localparam logic [HOLD_W-1:0] RST_RED_END       = HOLD_W'(900);
  localparam logic [HOLD_W-1:0] HOLD_MAX          = {HOLD_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH = 3'd0,
    REG_MAJORITY      = 3'd1,
    REG_GREEN_START   = 3'd2,
    REG_GREEN_END     = 3'd3,
    REG_RED_START     = 3'd4,
    REG_RED_END       = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [HOLD_W-1:0] green_start;
    logic [HOLD_W-1:0] green_end;
    logic [HOLD_W-1:0] red_start;
    logic [HOLD_W-1:0] red_end;
  } hold_cfg_t;

  typedef struct packed {
    logic              green_led;
    logic              red_led;
    logic              connect_pulse;
    logic              reset_pulse;
    logic [HOLD_W-1:0] hold_ticks;
  } hold_res_t;

endpackage

@@ design/bdhc_if.sv @@
// valid/ready channel interfaces for sample beats and result beats
// depends on bdhc_pkg
interface bdhc_in_if;
  logic valid;
  logic ready;
  logic raw_level;
  logic handler_tick;

  modport source (output valid, raw_level, handler_tick, input ready);
  modport sink (input valid, raw_level, handler_tick, output ready);
endinterface

interface bdhc_out_if import bdhc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              debounced_pressed;
  logic              green_led;
  logic              red_led;
  logic              connect_pulse;
  logic              reset_pulse;
  logic [HOLD_W-1:0] hold_ticks;

  modport source (output valid, debounced_pressed, green_led, red_led, connect_pulse,
                  reset_pulse, hold_ticks, input ready);
  modport sink (input valid, debounced_pressed, green_led, red_led, connect_pulse,
                reset_pulse, hold_ticks, output ready);
endinterface

@@ design/bdhc_debounce.sv @@
// majority-vote debounce over a window of raw samples
// depends on bdhc_pkg
module bdhc_debounce import bdhc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  logic             raw_level,
  input  logic [CNT_W-1:0] window_length,
  input  logic [CNT_W-1:0] majority_threshold,
  output logic             debounced_nxt
);

  logic [CNT_W-1:0] sample_cnt_r, sample_cnt_nxt;
  logic [CNT_W-1:0] pressed_cnt_r, pressed_cnt_nxt;
  logic             debounced_r;
  logic [CNT_W-1:0] sample_inc;
  logic [CNT_W-1:0] pressed_inc;

  // count samples and pressed samples, decide when the window closes
  always_comb begin
    sample_inc      = sample_cnt_r + CNT_W'(1);
    pressed_inc     = raw_level ? pressed_cnt_r : pressed_cnt_r + CNT_W'(1);
    sample_cnt_nxt  = sample_inc;
    pressed_cnt_nxt = pressed_inc;
    debounced_nxt   = debounced_r;
    if (sample_inc >= window_length) begin
      debounced_nxt   = (pressed_inc > majority_threshold);
      sample_cnt_nxt  = '0;
      pressed_cnt_nxt = '0;
    end
  end

  // state update once per sample beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_cnt_r  <= '0;
      pressed_cnt_r <= '0;
      debounced_r   <= 1'b0;
    end else if (step_en) begin
      sample_cnt_r  <= sample_cnt_nxt;
      pressed_cnt_r <= pressed_cnt_nxt;
      debounced_r   <= debounced_nxt;
    end
  end

endmodule

@@ design/bdhc_hold.sv @@
// hold counter with green and red windows, led latches and release pulses
// depends on bdhc_pkg
module bdhc_hold import bdhc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  logic      handler_tick,
  input  logic      debounced,
  input  hold_cfg_t cfg,
  output hold_res_t res
);

  logic [HOLD_W-1:0] hold_r, hold_nxt;
  logic              green_r, green_nxt;
  logic              red_r, red_nxt;
  logic [HOLD_W-1:0] hold_a;
  logic [HOLD_W-1:0] hold_b;
  logic              in_green;
  logic              in_red;
  logic              connect;
  logic              rst_pulse;

  // windows are checked in order, each on the count left by the one before
  always_comb begin
    hold_nxt  = hold_r;
    green_nxt = green_r;
    red_nxt   = red_r;
    connect   = 1'b0;
    rst_pulse = 1'b0;
    hold_a    = hold_r;
    hold_b    = hold_r;
    in_green  = 1'b0;
    in_red    = 1'b0;
    if (handler_tick) begin
      // green window
      in_green = (hold_r > cfg.green_start) && (hold_r < cfg.green_end);
      if (in_green) begin
        green_nxt = 1'b1;
        if (!debounced) begin
          hold_a    = '0;
          green_nxt = 1'b0;
          connect   = 1'b1;
        end
      end
      // gap between windows
      if ((hold_a > cfg.green_end) && (hold_a < cfg.red_start)) begin
        green_nxt = 1'b0;
      end
      // red window
      hold_b = hold_a;
      in_red = (hold_a > cfg.red_start) && (hold_a < cfg.red_end);
      if (in_red) begin
        red_nxt = 1'b1;
        if (!debounced) begin
          hold_b    = '0;
          red_nxt   = 1'b0;
          rst_pulse = 1'b1;
        end
      end
      // past red
      if (hold_b > cfg.red_end) begin
        red_nxt = 1'b0;
      end
      // count while pressed, saturating
      if (debounced) begin
        hold_nxt = (hold_b == HOLD_MAX) ? hold_b : hold_b + HOLD_W'(1);
      end else begin
        hold_nxt = '0;
      end
    end
  end

  assign res.green_led     = green_nxt;
  assign res.red_led       = red_nxt;
  assign res.connect_pulse = connect;
  assign res.reset_pulse   = rst_pulse;
  assign res.hold_ticks    = hold_nxt;

  // state update once per sample beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r  <= '0;
      green_r <= 1'b0;
      red_r   <= 1'b0;
    end else if (step_en) begin
      hold_r  <= hold_nxt;
      green_r <= green_nxt;
      red_r   <= red_nxt;
    end
  end

endmodule

@@ design/button_debounce_hold_classifier_top.sv @@
// top level of the button debounce and hold classifier
// depends on bdhc_pkg, bdhc_if, bdhc_debounce, bdhc_hold
//
//   channel   dir   beat contents
//   in_chan   in    raw_level, handler_tick (one 1 ms sample)
//   out_chan  out   debounced_pressed, green_led, red_led, connect_pulse,
//                   reset_pulse, hold_ticks
//   cfg_*     in    wr_en, index, wdata (six registers, write only)
//
// one beat per cycle sustained while the output is not stalled; an accepted beat
// passes through the input register, then logic into the result register.
// reset is synchronous: counters, latches and flag clear, registers take
// their default values. the input register moves on whenever the result
// register is empty or being taken, so a stalled output backs up one beat.
module button_debounce_hold_classifier_top import bdhc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  bdhc_in_if.sink               in_chan,
  bdhc_out_if.source            out_chan,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [CNT_W-1:0] window_length_r;
  logic [CNT_W-1:0] majority_r;
  hold_cfg_t        hold_cfg_r;

  logic      s1_valid_r, s1_valid_nxt;
  logic      s1_raw_r;
  logic      s1_tick_r;
  logic      out_valid_r;
  logic      out_db_r;
  hold_res_t out_res_r;

  logic      advance;
  logic      step_en;
  logic      in_fire;
  logic      debounced;
  hold_res_t hold_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r        <= RST_WINDOW_LENGTH;
      majority_r             <= RST_MAJORITY;
      hold_cfg_r.green_start <= RST_GREEN_START;
      hold_cfg_r.green_end   <= RST_GREEN_END;
      hold_cfg_r.red_start   <= RST_RED_START;
      hold_cfg_r.red_end     <= RST_RED_END;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_WINDOW_LENGTH: window_length_r        <= cfg_wdata[CNT_W-1:0];
        REG_MAJORITY:      majority_r             <= cfg_wdata[CNT_W-1:0];
        REG_GREEN_START:   hold_cfg_r.green_start <= cfg_wdata[HOLD_W-1:0];
        REG_GREEN_END:     hold_cfg_r.green_end   <= cfg_wdata[HOLD_W-1:0];
        REG_RED_START:     hold_cfg_r.red_start   <= cfg_wdata[HOLD_W-1:0];
        REG_RED_END:       hold_cfg_r.red_end     <= cfg_wdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake and pipeline advance
  assign advance       = !out_valid_r || out_chan.ready;
  assign step_en       = s1_valid_r && advance;
  assign in_chan.ready = !s1_valid_r || advance;
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_raw_r  <= in_chan.raw_level;
      s1_tick_r <= in_chan.handler_tick;
    end
  end

  bdhc_debounce u_debounce (
    .clk                (clk),
    .rst_n              (rst_n),
    .step_en            (step_en),
    .raw_level          (s1_raw_r),
    .window_length      (window_length_r),
    .majority_threshold (majority_r),
    .debounced_nxt      (debounced)
  );

  bdhc_hold u_hold (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (step_en),
    .handler_tick (s1_tick_r),
    .debounced    (debounced),
    .cfg          (hold_cfg_r),
    .res          (hold_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_db_r  <= debounced;
      out_res_r <= hold_res;
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.debounced_pressed = out_db_r;
  assign out_chan.green_led         = out_res_r.green_led;
  assign out_chan.red_led           = out_res_r.red_led;
  assign out_chan.connect_pulse     = out_res_r.connect_pulse;
  assign out_chan.reset_pulse       = out_res_r.reset_pulse;
  assign out_chan.hold_ticks        = out_res_r.hold_ticks;

endmodule
